// ===== sv/assert_macros.svh =====
// assertion macros used by the hash map engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication on clk, off during rst
`define OCHM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ochm check failed");

// next-cycle implication on clk, off during rst
`define OCHM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ochm check failed");

`endif

// ===== sv/ochm_pkg.sv =====
// types and constants of the ordered chained hash map
package ochm_pkg;

  localparam int CAPACITY  = 64;
  localparam int AW        = 6;             // entry/bucket address bits
  localparam int IW        = 7;             // index bits, holds CAPACITY
  localparam logic [IW-1:0] LINK_END  = IW'(CAPACITY);
  localparam logic [IW-1:0] LINK_HOLE = IW'(CAPACITY + 1);
  localparam logic [IW-1:0] LOAD_MARK = IW'(CAPACITY * 3 / 4);

  localparam logic [2:0] CMD_LOOKUP = 3'd0;
  localparam logic [2:0] CMD_STORE  = 3'd1;
  localparam logic [2:0] CMD_REMOVE = 3'd2;
  localparam logic [2:0] CMD_NEXT   = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_MISS   = 2'd1;
  localparam logic [1:0] ST_LOCKED = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic [2:0]    cmd;
    logic [63:0]   key;
    logic [31:0]   khash;
    logic [63:0]   value;
    logic [IW-1:0] position;
  } ochm_in_t;

  typedef struct packed {
    logic [1:0]    status;
    logic [63:0]   value_out;
    logic [63:0]   key_out;
    logic [IW-1:0] index_out;
    logic [IW-1:0] live_count;
  } ochm_out_t;

  typedef struct packed {
    logic [63:0]   key;
    logic [63:0]   value;
    logic [31:0]   hash;
    logic [IW-1:0] link;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== sv/ochm_ram.sv =====
// generic single-write, single-read ram with registered read data
module ochm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/ordered_chained_hash_map.sv =====
// ordered chained hash map engine: bucket head ram, entry ram, command sequencer
//
//   channel   direction  beat marked by        payload
//   command   in         start & !busy         op (ochm_in_t)
//   result    out        done, one cycle       res (ochm_out_t)
//   lock      in         lock_we               lock_wdata
//
// a command that fails at once is answered straight from idle; lookup/store/remove read the
// bucket head, then visit the chain entries (with an unlink step behind a predecessor);
// next reads entries from position on, skipping holes; clear sweeps every bucket head; a store
// that compacts sweeps the heads, moves each live entry below the high-water mark down, then
// walks the chain again. after rst the bucket heads are swept with busy high.
// the result register frees the sequencer; results cannot be held off.
`include "assert_macros.svh"

module ordered_chained_hash_map
  import ochm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  ochm_in_t  op,
  output logic      done,
  output ochm_out_t res,
  input  logic      lock_we,
  input  logic      lock_wdata
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_CLR    = 9'b000000010,
    S_HEAD   = 9'b000000100,
    S_WALK   = 9'b000001000,
    S_UNLINK = 9'b000010000,
    S_SCAN   = 9'b000100000,
    S_CRD    = 9'b001000000,
    S_CHD    = 9'b010000000,
    S_RETRY  = 9'b100000000
  } state_t;

  state_t state, state_next;

  logic           write_lock;
  ochm_in_t       cur_op, cur_op_next;
  logic [IW-1:0]  cur, cur_next, prev, prev_next, head_q, head_q_next;
  entry_t         prev_data, prev_data_next, hold, hold_next;
  logic [IW-1:0]  src, src_next, dst, dst_next;
  logic [AW-1:0]  cnt, cnt_next;
  logic           comp, comp_next, report, report_next;
  logic [IW-1:0]  high_water, high_water_next, hole_count, hole_count_next;
  logic           done_next;
  ochm_out_t      res_next;

  logic           head_we;
  logic [AW-1:0]  head_waddr, head_raddr;
  logic [IW-1:0]  head_wdata, head_rdata;
  logic           ent_we;
  logic [AW-1:0]  ent_waddr, ent_raddr;
  entry_t         ent_wdata, ent_rdata;
  logic [ENTRY_W-1:0] ent_rraw;

  logic           do_miss;
  logic [AW-1:0]  bucket;

  ochm_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_head_ram (
    .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .raddr(head_raddr), .rdata(head_rdata)
  );

  ochm_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_entry_ram (
    .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
    .raddr(ent_raddr), .rdata(ent_rraw)
  );

  assign ent_rdata = entry_t'(ent_rraw);
  assign bucket    = cur_op.khash[AW-1:0];
  assign busy      = (state != S_IDLE);

  always_comb begin
    state_next      = state;
    cur_op_next     = cur_op;
    cur_next        = cur;
    prev_next       = prev;
    prev_data_next  = prev_data;
    head_q_next     = head_q;
    hold_next       = hold;
    src_next        = src;
    dst_next        = dst;
    cnt_next        = cnt;
    comp_next       = comp;
    report_next     = report;
    high_water_next = high_water;
    hole_count_next = hole_count;
    done_next       = 1'b0;
    res_next        = '{status: ST_MISS, value_out: '0, key_out: '0,
                        index_out: LINK_END, live_count: '0};
    head_we    = 1'b0;
    head_waddr = bucket;
    head_wdata = LINK_END;
    head_raddr = bucket;
    ent_we     = 1'b0;
    ent_waddr  = cur[AW-1:0];
    ent_wdata  = ent_rdata;
    ent_raddr  = cur[AW-1:0];
    do_miss    = 1'b0;

    case (state)
      S_IDLE: begin
        if (start) begin
          cur_op_next = op;
          case (op.cmd)
            CMD_LOOKUP, CMD_STORE, CMD_REMOVE: begin
              if (write_lock && op.cmd != CMD_LOOKUP) begin
                done_next       = 1'b1;
                res_next.status = ST_LOCKED;
              end else begin
                head_raddr = op.khash[AW-1:0];
                state_next = S_HEAD;
              end
            end
            CMD_NEXT: begin
              if (op.position >= high_water) begin
                done_next = 1'b1;
              end else begin
                cur_next   = op.position;
                ent_raddr  = op.position[AW-1:0];
                state_next = S_SCAN;
              end
            end
            CMD_CLEAR: begin
              if (write_lock) begin
                done_next       = 1'b1;
                res_next.status = ST_LOCKED;
              end else begin
                cnt_next    = '0;
                comp_next   = 1'b0;
                report_next = 1'b1;
                state_next  = S_CLR;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end

      S_CLR: begin
        head_we    = 1'b1;
        head_waddr = cnt;
        head_wdata = LINK_END;
        cnt_next   = cnt + 1'b1;
        if (cnt == AW'(CAPACITY - 1)) begin
          if (comp) begin
            src_next   = '0;
            dst_next   = '0;
            ent_raddr  = '0;
            state_next = S_CRD;
          end else begin
            high_water_next = '0;
            hole_count_next = '0;
            state_next      = S_IDLE;
            if (report) begin
              done_next       = 1'b1;
              res_next.status = ST_OK;
            end
          end
        end
      end

      S_HEAD: begin
        head_q_next = head_rdata;
        cur_next    = head_rdata;
        prev_next   = LINK_END;
        if (head_rdata == LINK_END) begin
          do_miss = 1'b1;
        end else begin
          ent_raddr  = head_rdata[AW-1:0];
          state_next = S_WALK;
        end
      end

      S_WALK: begin
        if (ent_rdata.hash == cur_op.khash && ent_rdata.key == cur_op.key) begin
          res_next.status    = ST_OK;
          res_next.index_out = cur;
          case (cur_op.cmd)
            CMD_STORE: begin
              ent_we          = 1'b1;
              ent_wdata.value = cur_op.value;
              done_next       = 1'b1;
              state_next      = S_IDLE;
            end
            CMD_REMOVE: begin
              hold_next = ent_rdata;
              if (prev == LINK_END) begin
                head_we    = 1'b1;
                head_wdata = ent_rdata.link;
                ent_we     = 1'b1;
                ent_wdata  = '{key: '0, value: '0, hash: '0, link: LINK_HOLE};
                hole_count_next = hole_count + 1'b1;
                done_next       = 1'b1;
                state_next      = S_IDLE;
              end else begin
                // unlink from the predecessor, mark the hole next cycle
                ent_we         = 1'b1;
                ent_waddr      = prev[AW-1:0];
                ent_wdata      = prev_data;
                ent_wdata.link = ent_rdata.link;
                state_next     = S_UNLINK;
              end
            end
            default: begin
              res_next.value_out = ent_rdata.value;
              done_next          = 1'b1;
              state_next         = S_IDLE;
            end
          endcase
        end else begin
          prev_next      = cur;
          prev_data_next = ent_rdata;
          cur_next       = ent_rdata.link;
          if (ent_rdata.link == LINK_END) begin
            do_miss = 1'b1;
          end else begin
            ent_raddr = ent_rdata.link[AW-1:0];
          end
        end
      end

      S_UNLINK: begin
        ent_we    = 1'b1;
        ent_wdata = '{key: '0, value: '0, hash: '0, link: LINK_HOLE};
        hole_count_next    = hole_count + 1'b1;
        res_next.status    = ST_OK;
        res_next.index_out = cur;
        done_next          = 1'b1;
        state_next         = S_IDLE;
      end

      S_SCAN: begin
        if (ent_rdata.link != LINK_HOLE) begin
          res_next.status    = ST_OK;
          res_next.value_out = ent_rdata.value;
          res_next.key_out   = ent_rdata.key;
          res_next.index_out = cur;
          done_next          = 1'b1;
          state_next         = S_IDLE;
        end else if (cur + 1'b1 >= high_water) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          cur_next  = cur + 1'b1;
          ent_raddr = AW'(cur + 1'b1);
        end
      end

      S_CRD: begin
        hold_next = ent_rdata;
        if (ent_rdata.link == LINK_HOLE) begin
          src_next = src + 1'b1;
          if (src + 1'b1 == high_water) begin
            high_water_next = dst;
            hole_count_next = '0;
            state_next      = S_RETRY;
          end else begin
            ent_raddr = AW'(src + 1'b1);
          end
        end else begin
          head_raddr = ent_rdata.hash[AW-1:0];
          state_next = S_CHD;
        end
      end

      S_CHD: begin
        // live entry moves down to dst and is pushed on its chain
        ent_we         = 1'b1;
        ent_waddr      = dst[AW-1:0];
        ent_wdata      = hold;
        ent_wdata.link = head_rdata;
        head_we        = 1'b1;
        head_waddr     = hold.hash[AW-1:0];
        head_wdata     = dst;
        dst_next       = dst + 1'b1;
        src_next       = src + 1'b1;
        if (src + 1'b1 == high_water) begin
          high_water_next = dst + 1'b1;
          hole_count_next = '0;
          state_next      = S_RETRY;
        end else begin
          ent_raddr  = AW'(src + 1'b1);
          state_next = S_CRD;
        end
      end

      S_RETRY: begin
        head_raddr = bucket;
        state_next = S_HEAD;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (do_miss) begin
      state_next = S_IDLE;
      if (cur_op.cmd == CMD_STORE) begin
        if (high_water >= LOAD_MARK && hole_count != '0) begin
          cnt_next    = '0;
          comp_next   = 1'b1;
          report_next = 1'b0;
          state_next  = S_CLR;
        end else if (high_water >= LINK_END) begin
          done_next       = 1'b1;
          res_next.status = ST_FULL;
        end else begin
          ent_we     = 1'b1;
          ent_waddr  = high_water[AW-1:0];
          ent_wdata  = '{key: cur_op.key, value: cur_op.value,
                         hash: cur_op.khash, link: head_q_next};
          head_we    = 1'b1;
          head_wdata = high_water;
          high_water_next    = high_water + 1'b1;
          res_next.status    = ST_OK;
          res_next.index_out = high_water;
          done_next          = 1'b1;
        end
      end else begin
        done_next = 1'b1;
      end
    end

    res_next.live_count = high_water_next - hole_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      cnt        <= '0;
      comp       <= 1'b0;
      report     <= 1'b0;
      high_water <= '0;
      hole_count <= '0;
      write_lock <= 1'b0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      comp       <= comp_next;
      report     <= report_next;
      high_water <= high_water_next;
      hole_count <= hole_count_next;
      done       <= done_next;
      if (lock_we) begin
        write_lock <= lock_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_op    <= cur_op_next;
    cur       <= cur_next;
    prev      <= prev_next;
    prev_data <= prev_data_next;
    head_q    <= head_q_next;
    hold      <= hold_next;
    src       <= src_next;
    dst       <= dst_next;
    res       <= res_next;
  end

  `OCHM_ASSERT_IMP(a_done_idle, done, state == S_IDLE)
  `OCHM_ASSERT_IMP(a_holes_bounded, 1'b1, hole_count <= high_water)
  `OCHM_ASSERT_IMP(a_hw_bounded, 1'b1, high_water <= LINK_END)
  `OCHM_ASSERT_NXT(a_accept_progress, start && !busy, busy || done)

endmodule

// ===== verif/ordered_chained_hash_map_test.sv =====
// testbench for the ordered chained hash map: directed and random commands checked against a behavioral map
`timescale 1ns / 100ps

module ordered_chained_hash_map_test
  import ochm_pkg::*;
();

  class map_scoreboard;
    logic [IW-1:0] head [CAPACITY];
    logic [63:0]   ekey [CAPACITY];
    logic [63:0]   eval [CAPACITY];
    logic [31:0]   ehash [CAPACITY];
    logic [IW-1:0] elink [CAPACITY];
    int unsigned   high_water;
    int unsigned   holes;
    bit            locked;
    ochm_out_t     pending [$];
    int            errors;

    function void wipe();
      for (int i = 0; i < CAPACITY; i++) begin
        head[i] = LINK_END;
        ekey[i] = '0;
        eval[i] = '0;
        ehash[i] = '0;
        elink[i] = LINK_END;
      end
      high_water = 0;
      holes = 0;
    endfunction

    function int find(logic [63:0] k, logic [31:0] h, output int prev);
      int i;
      int p;
      int steps;
      i = head[h[AW-1:0]];
      p = CAPACITY;
      steps = 0;
      prev = CAPACITY;
      while (i < CAPACITY && steps < CAPACITY) begin
        if (ehash[i] == h && ekey[i] == k) begin
          prev = p;
          return i;
        end
        p = i;
        i = elink[i];
        steps++;
      end
      return CAPACITY;
    endfunction

    function void squeeze();
      int dst;
      dst = 0;
      for (int i = 0; i < CAPACITY; i++) head[i] = LINK_END;
      for (int i = 0; i < high_water; i++) begin
        if (elink[i] == LINK_HOLE) continue;
        ekey[dst] = ekey[i];
        eval[dst] = eval[i];
        ehash[dst] = ehash[i];
        elink[dst] = head[ehash[i][AW-1:0]];
        head[ehash[i][AW-1:0]] = IW'(dst);
        dst++;
      end
      for (int i = dst; i < CAPACITY; i++) begin
        ekey[i] = '0;
        eval[i] = '0;
        ehash[i] = '0;
        elink[i] = LINK_END;
      end
      high_water = dst;
      holes = 0;
    endfunction

    // predict the result of one accepted command beat
    function void note_command(ochm_in_t c);
      ochm_out_t r;
      int idx;
      int prev;
      r = '0;
      r.status = ST_MISS;
      r.index_out = LINK_END;
      case (c.cmd)
        CMD_LOOKUP: begin
          idx = find(c.key, c.khash, prev);
          if (idx < CAPACITY) begin
            r.status = ST_OK;
            r.value_out = eval[idx];
            r.index_out = IW'(idx);
          end
        end
        CMD_STORE: begin
          if (locked) r.status = ST_LOCKED;
          else begin
            idx = find(c.key, c.khash, prev);
            if (idx < CAPACITY) begin
              eval[idx] = c.value;
              r.status = ST_OK;
              r.index_out = IW'(idx);
            end else begin
              if (high_water * 4 >= CAPACITY * 3 && holes > 0) squeeze();
              if (high_water >= CAPACITY) r.status = ST_FULL;
              else begin
                idx = high_water;
                ekey[idx] = c.key;
                eval[idx] = c.value;
                ehash[idx] = c.khash;
                elink[idx] = head[c.khash[AW-1:0]];
                head[c.khash[AW-1:0]] = IW'(idx);
                high_water++;
                r.status = ST_OK;
                r.index_out = IW'(idx);
              end
            end
          end
        end
        CMD_REMOVE: begin
          if (locked) r.status = ST_LOCKED;
          else begin
            idx = find(c.key, c.khash, prev);
            if (idx < CAPACITY) begin
              if (prev < CAPACITY) elink[prev] = elink[idx];
              else head[c.khash[AW-1:0]] = elink[idx];
              elink[idx] = LINK_HOLE;
              ekey[idx] = '0;
              eval[idx] = '0;
              ehash[idx] = '0;
              holes++;
              r.status = ST_OK;
              r.index_out = IW'(idx);
            end
          end
        end
        CMD_NEXT: begin
          for (int i = c.position; i < high_water; i++) begin
            if (elink[i] != LINK_HOLE) begin
              r.status = ST_OK;
              r.value_out = eval[i];
              r.key_out = ekey[i];
              r.index_out = IW'(i);
              break;
            end
          end
        end
        CMD_CLEAR: begin
          if (locked) r.status = ST_LOCKED;
          else begin
            wipe();
            r.status = ST_OK;
          end
        end
        default: ;
      endcase
      r.live_count = IW'(high_water - holes);
      pending.push_back(r);
    endfunction

    function void check_result(ochm_out_t got);
      ochm_out_t want;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) begin
        $error("status expected %0d actual %0d", want.status, got.status);
        errors++;
      end
      if (got.value_out !== want.value_out) begin
        $error("value_out expected %h actual %h", want.value_out, got.value_out);
        errors++;
      end
      if (got.key_out !== want.key_out) begin
        $error("key_out expected %h actual %h", want.key_out, got.key_out);
        errors++;
      end
      if (got.index_out !== want.index_out) begin
        $error("index_out expected %0d actual %0d", want.index_out, got.index_out);
        errors++;
      end
      if (got.live_count !== want.live_count) begin
        $error("live_count expected %0d actual %0d", want.live_count, got.live_count);
        errors++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  ochm_in_t  op;
  logic      done;
  ochm_out_t res;
  logic      lock_we;
  logic      lock_wdata;

  map_scoreboard board;
  int unsigned   gap_pct;
  logic [63:0]   key_pool [16];
  logic [31:0]   hash_pool [16];

  ordered_chained_hash_map u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .done(done), .res(res), .lock_we(lock_we), .lock_wdata(lock_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && done) board.check_result(res);
  end

  // one command beat, with a random idle gap before it; start stays up after the beat
  task automatic send(ochm_in_t c);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    op <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_command(c);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_lock(bit v);
    drain();
    lock_we <= 1'b1;
    lock_wdata <= v;
    @(posedge clk);
    board.locked = v;
    lock_we <= 1'b0;
  endtask

  function automatic ochm_in_t make_cmd(logic [2:0] cmd, int slot);
    ochm_in_t c;
    c.cmd = cmd;
    c.key = key_pool[slot];
    c.khash = hash_pool[slot];
    c.value = {$urandom, $urandom};
    c.position = IW'($urandom_range(CAPACITY));
    return c;
  endfunction

  function automatic ochm_in_t random_cmd();
    ochm_in_t c;
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) c = make_cmd(CMD_STORE, $urandom_range(15));
    else if (pick < 60) c = make_cmd(CMD_LOOKUP, $urandom_range(15));
    else if (pick < 78) c = make_cmd(CMD_REMOVE, $urandom_range(15));
    else if (pick < 92) c = make_cmd(CMD_NEXT, $urandom_range(15));
    else if (pick < 94) c = make_cmd(CMD_CLEAR, 0);
    else begin
      // noise: fresh key and hash, with a random command code that may be unknown
      c = make_cmd(3'($urandom_range(7)), 0);
      c.key = {$urandom, $urandom};
      c.khash = $urandom;
    end
    return c;
  endfunction

  initial begin
    ochm_in_t c;
    board = new();
    board.wipe();
    board.locked = 1'b0;
    board.errors = 0;
    rst = 1'b1;
    start = 1'b0;
    op = '0;
    lock_we = 1'b0;
    lock_wdata = 1'b0;
    gap_pct = 0;
    for (int i = 0; i < 16; i++) begin
      key_pool[i] = {$urandom, $urandom};
      // several keys share a bucket, and two share the full hash
      hash_pool[i] = (i < 4) ? {8'($urandom_range(255)), 8'd0, 16'h0005} : $urandom;
    end
    hash_pool[1] = hash_pool[0];
    key_pool[2] = key_pool[0];
    key_pool[15] = '1;
    hash_pool[15] = '1;
    key_pool[14] = '0;
    hash_pool[14] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, every command, unknown codes
    send(make_cmd(CMD_LOOKUP, 15));
    send(make_cmd(CMD_NEXT, 0));
    for (int i = 0; i < 4; i++) send(make_cmd(CMD_STORE, i));
    send(make_cmd(CMD_STORE, 15));
    send(make_cmd(CMD_STORE, 14));
    send(make_cmd(CMD_STORE, 1));
    send(make_cmd(CMD_LOOKUP, 2));
    send(make_cmd(CMD_REMOVE, 1));
    send(make_cmd(CMD_LOOKUP, 1));
    c = make_cmd(CMD_NEXT, 0);
    c.position = 7'd1;
    send(c);
    c.position = 7'd64;
    send(c);
    c.position = 7'd127;
    send(c);
    send(make_cmd(3'd5, 0));
    send(make_cmd(3'd7, 15));
    set_lock(1'b1);
    send(make_cmd(CMD_STORE, 5));
    send(make_cmd(CMD_REMOVE, 0));
    send(make_cmd(CMD_CLEAR, 0));
    send(make_cmd(CMD_LOOKUP, 0));
    set_lock(1'b0);
    send(make_cmd(CMD_CLEAR, 0));

    // fill to full, punch holes, then force compaction and the full status
    for (int i = 0; i < 70; i++) begin
      c = make_cmd(CMD_STORE, 0);
      c.key = {$urandom, $urandom};
      c.khash = $urandom;
      if (i == 50) c.value = '1;
      send(c);
      if (i == 10 || i == 20) begin
        c.cmd = CMD_REMOVE;
        send(c);
      end
    end
    drain();
    send(make_cmd(CMD_CLEAR, 0));

    for (int phase = 0; phase < 3; phase++) begin
      gap_pct = (phase == 0) ? 25 : (phase == 1) ? 88 : 0;
      if (phase == 1) set_lock(1'b1);
      for (int n = 0; n < 60; n++) send(random_cmd());
      if (phase == 1) set_lock(1'b0);
      for (int n = 0; n < 140; n++) send(random_cmd());
      drain();
    end

    drain();
    if (board.errors == 0 && board.pending.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/ochm_pkg.sv
sv/ochm_ram.sv
sv/ordered_chained_hash_map.sv
verif/ordered_chained_hash_map_test.sv
